FILE: design/htc_pkg.sv
// ----------------------------------------------------------------------------
// htc_pkg: shared types and constants for the Hermite tone curve evaluator
// Node entry layout, sequencer states, divider status and fixed-point limits.
// ----------------------------------------------------------------------------
`default_nettype none

package htc_pkg;

   localparam int MAX_NODES_DEFAULT = 32;

   // 1.0 in output level units
   localparam logic [15:0] LEVEL_ONE = 16'hFFFF;

   // divider geometry
   localparam int DIV_W     = 48;
   localparam int DIVISOR_W = 16;

   typedef struct packed {
      logic        [15:0] key;
      logic        [15:0] level;
      logic signed [23:0] slope_start;
      logic signed [23:0] slope_end;
   } node_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SEG0,
      ST_SEG1,
      ST_DIV_T,
      ST_MUL_A,
      ST_MUL_C,
      ST_DIV_C,
      ST_HB,
      ST_MAC,
      ST_CLAMP,
      ST_DIV_Q1,
      ST_DIV_Q2,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: design/htc_node_mem.sv
// ----------------------------------------------------------------------------
// htc_node_mem: node table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module htc_node_mem #(
   parameter int DEPTH = htc_pkg::MAX_NODES_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire htc_pkg::node_type         wr_data,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output htc_pkg::node_type              rd_data
);

   htc_pkg::node_type mem_ff [DEPTH];
   htc_pkg::node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/htc_div.sv
// ----------------------------------------------------------------------------
// htc_div: unsigned divider
// Restoring shift-subtract, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module htc_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [htc_pkg::DIV_W-1:0]         dividend,
   input  wire logic [htc_pkg::DIVISOR_W-1:0]     divisor,
   output logic      [htc_pkg::DIV_W-1:0]         quotient,
   output htc_pkg::div_stat_type                  stat
);

   localparam int W  = htc_pkg::DIV_W;
   localparam int DW = htc_pkg::DIVISOR_W;
   localparam int CW = $clog2(W + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0]  quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] dsr_ff;

   logic [DW:0]   rem_sh;
   logic          ge;
   logic [DW:0]   rem_sub;
   logic [DW-1:0] rem_in;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[W-1]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      rem_in  = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

FILE: design/hermite_tone_curve_eval.sv
// ----------------------------------------------------------------------------
// hermite_tone_curve_eval: tone curve made of cubic Hermite segments
// Node table in memory, sequencer with scan, bit-serial divider and one MAC.
// ----------------------------------------------------------------------------
// A load item writes its slot as it is accepted, when the slot index lies
// below MAX_NODES, and the block stays idle. An evaluate item first scans all
// n active nodes through the single read port of the node table (one node per
// cycle). A node hit, an input below the first key, an input at or beyond the
// last node or a segment whose next key is not above its start then goes
// straight to the final state. An input inside a segment runs one 48-step
// division on the bit-serial divider for the segment position, a fold unit
// that divides by 65535 once for the cube scaling and twice for the output
// scaling, and a multiply-accumulate over the four basis terms. One item
// is in work at a time; a finished result sits in the output register while
// the next item is accepted; a result not yet taken holds the block in FINISH.
`default_nettype none

module hermite_tone_curve_eval #(
   parameter int MAX_NODES = htc_pkg::MAX_NODES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_action,
   input  wire logic [15:0]        req_pixel_in,
   input  wire logic [4:0]         req_node_index,
   input  wire logic [15:0]        req_node_x,
   input  wire logic [15:0]        req_node_y,
   input  wire logic signed [23:0] req_tangent_start,
   input  wire logic signed [23:0] req_tangent_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_pixel_out,
   input  wire logic               csr_write_enable,
   input  wire logic [5:0]         csr_write_data
);

   localparam int IW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int NW = (CW > 6) ? CW : 6;
   localparam int SW = (IW > 5) ? IW : 5;
   localparam int DIVW = htc_pkg::DIV_W;

   localparam logic signed [35:0] D_SQ    = 36'sh0FFFE0001;
   localparam logic        [55:0] Q_LIMIT = 56'hFFFE_0001_0000;

   htc_pkg::state_type state_ff, state_in;

   logic [5:0]  node_count_ff;

   logic [15:0] x_ff, x_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] seg_ff, seg_in;
   logic        found_ff, found_in;
   logic [15:0] k0_ff, k0_in;
   logic [15:0] y0_ff, y0_in;
   logic [15:0] y1_ff, y1_in;
   logic signed [23:0] m0_ff, m0_in;
   logic signed [23:0] m1_ff, m1_in;
   logic [15:0] ti_ff, ti_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] c_ff, c_in;
   logic signed [35:0] h00_ff, h00_in, h01_ff, h01_in, h10_ff, h10_in, h11_ff, h11_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [2:0]  mac_cnt_ff, mac_cnt_in;
   logic [15:0] res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_pixel_ff, rsp_pixel_in;
   logic [47:0] fold_s_ff, fold_s_in;
   logic [47:0] fold_q_ff, fold_q_in;

   // active node count clamped to 2..MAX_NODES
   logic [NW-1:0] cnt_ext, n_wide;
   logic [IW-1:0] idx_last;

   always_comb begin
      cnt_ext = NW'(node_count_ff);
      if (cnt_ext < NW'(2)) begin
         n_wide = NW'(2);
      end else if (cnt_ext > NW'(MAX_NODES)) begin
         n_wide = NW'(MAX_NODES);
      end else begin
         n_wide = cnt_ext;
      end
      idx_last = IW'(n_wide - NW'(1));
   end

   // node table
   logic              accept;
   logic              accept_eval;
   logic [SW-1:0]     slot_ext;
   logic              slot_ok;
   logic              wr_en;
   htc_pkg::node_type wr_data;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   htc_pkg::node_type rd_data;

   assign req_ready   = (state_ff == htc_pkg::ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign accept_eval = accept && !req_action;
   assign slot_ext    = SW'(req_node_index);
   assign slot_ok     = {1'b0, slot_ext} < (SW + 1)'(MAX_NODES);
   assign wr_en       = accept && req_action && slot_ok;

   always_comb begin
      wr_data.key         = req_node_x;
      wr_data.level       = req_node_y;
      wr_data.slope_start = req_tangent_start;
      wr_data.slope_end   = req_tangent_end;
   end

   htc_node_mem #(
      .DEPTH(MAX_NODES)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(slot_ext[IW-1:0]),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // divider
   logic                  div_start;
   logic [DIVW-1:0]       div_dividend;
   logic [15:0]           div_divisor;
   logic [DIVW-1:0]       div_quot;
   htc_pkg::div_stat_type div_stat;

   htc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .quotient(div_quot),
      .stat    (div_stat)
   );

   // scan and segment decisions
   logic        scan_hit;
   logic        scan_last;
   logic        seg0_direct;
   logic        span_bad;
   logic [15:0] dx;
   logic [31:0] dx_scaled;
   logic signed [63:0] n_val;
   logic [55:0] m_val;
   logic        out_free;

   assign scan_hit    = rd_data.key <= x_ff;
   assign scan_last   = (rd_idx_ff == idx_last);
   assign seg0_direct = !found_ff || (rd_data.key == x_ff) || (seg_ff == idx_last);
   assign span_bad    = rd_data.key <= k0_ff;
   assign dx          = x_ff - k0_ff;
   assign dx_scaled   = {dx, 16'h0000} - {16'h0000, dx};
   assign n_val       = acc_ff;
   assign m_val       = n_val[63:8];
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // division by 65535: s = h*65536 + l folds to q += h, s = h + l
   logic [31:0] fold_hi;
   logic        fold_busy;
   logic [47:0] fold_quo;

   assign fold_hi   = fold_s_ff[47:16];
   assign fold_busy = (fold_hi != 32'd0);
   assign fold_quo  = fold_q_ff +
                      ((fold_s_ff[15:0] == htc_pkg::LEVEL_ONE) ? 48'd1 : 48'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         htc_pkg::ST_IDLE:   if (accept_eval) state_in = htc_pkg::ST_SCAN;
         htc_pkg::ST_SCAN:   if (scan_last) state_in = htc_pkg::ST_SEG0;
         htc_pkg::ST_SEG0: begin
            state_in = seg0_direct ? htc_pkg::ST_FINISH : htc_pkg::ST_SEG1;
         end
         htc_pkg::ST_SEG1: begin
            state_in = span_bad ? htc_pkg::ST_FINISH : htc_pkg::ST_DIV_T;
         end
         htc_pkg::ST_DIV_T:  if (div_stat.done) state_in = htc_pkg::ST_MUL_A;
         htc_pkg::ST_MUL_A:  state_in = htc_pkg::ST_MUL_C;
         htc_pkg::ST_MUL_C:  state_in = htc_pkg::ST_DIV_C;
         htc_pkg::ST_DIV_C:  if (!fold_busy) state_in = htc_pkg::ST_HB;
         htc_pkg::ST_HB:     state_in = htc_pkg::ST_MAC;
         htc_pkg::ST_MAC:    if (mac_cnt_ff == 3'd4) state_in = htc_pkg::ST_CLAMP;
         htc_pkg::ST_CLAMP: begin
            if (n_val < 0 || m_val >= Q_LIMIT) begin
               state_in = htc_pkg::ST_FINISH;
            end else begin
               state_in = htc_pkg::ST_DIV_Q1;
            end
         end
         htc_pkg::ST_DIV_Q1: if (!fold_busy) state_in = htc_pkg::ST_DIV_Q2;
         htc_pkg::ST_DIV_Q2: if (!fold_busy) state_in = htc_pkg::ST_FINISH;
         htc_pkg::ST_FINISH: if (out_free) state_in = htc_pkg::ST_IDLE;
         default:            state_in = htc_pkg::ST_IDLE;
      endcase
   end

   // MAC operands
   logic signed [24:0] mul_a;
   logic signed [35:0] mul_b;
   logic signed [60:0] mul_p;
   logic signed [63:0] mul_p64;

   always_comb begin
      unique case (mac_cnt_ff)
         3'd0:    begin mul_a = $signed({9'b0, y0_ff}); mul_b = h00_ff; end
         3'd1:    begin mul_a = $signed({9'b0, y1_ff}); mul_b = h01_ff; end
         3'd2:    begin mul_a = 25'(m0_ff); mul_b = h10_ff; end
         default: begin mul_a = 25'(m1_ff); mul_b = h11_ff; end
      endcase
      mul_p   = mul_a * mul_b;
      mul_p64 = 64'(mul_p);
   end

   logic signed [35:0] a_s, c_s, ti_d;
   assign a_s  = $signed({4'b0, a_ff});
   assign c_s  = $signed({4'b0, c_ff});
   assign ti_d = $signed({4'b0, ti_ff, 16'h0000}) - $signed({20'b0, ti_ff});

   // control and datapath
   always_comb begin
      x_in = x_ff;  rd_idx_in = rd_idx_ff;  seg_in = seg_ff;  found_in = found_ff;
      k0_in = k0_ff;  y0_in = y0_ff;  y1_in = y1_ff;  m0_in = m0_ff;  m1_in = m1_ff;
      ti_in = ti_ff;  a_in = a_ff;  c_in = c_ff;
      h00_in = h00_ff;  h01_in = h01_ff;  h10_in = h10_ff;  h11_in = h11_ff;
      acc_in = acc_ff;  prod_in = prod_ff;  mac_cnt_in = mac_cnt_ff;
      res_in = res_ff;
      fold_s_in = fold_s_ff;  fold_q_in = fold_q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in = rsp_pixel_ff;
      rd_en = 1'b0;  rd_addr = '0;
      div_start = 1'b0;  div_dividend = '0;  div_divisor = htc_pkg::LEVEL_ONE;

      unique case (state_ff)
         htc_pkg::ST_IDLE: begin
            if (accept_eval) begin
               x_in      = req_pixel_in;
               rd_idx_in = '0;
               found_in  = 1'b0;
               seg_in    = '0;
               rd_en     = 1'b1;
            end
         end
         htc_pkg::ST_SCAN: begin
            if (scan_hit) begin
               seg_in   = rd_idx_ff;
               found_in = 1'b1;
            end
            rd_en = 1'b1;
            if (scan_last) begin
               // fetch the chosen node, or the first one when none is below
               rd_addr = scan_hit ? rd_idx_ff : (found_ff ? seg_ff : '0);
            end else begin
               rd_addr   = rd_idx_ff + IW'(1);
               rd_idx_in = rd_idx_ff + IW'(1);
            end
         end
         htc_pkg::ST_SEG0: begin
            k0_in   = rd_data.key;
            y0_in   = rd_data.level;
            m0_in   = rd_data.slope_start;
            m1_in   = rd_data.slope_end;
            res_in  = rd_data.level;
            rd_en   = 1'b1;
            rd_addr = seg_ff + IW'(1);
         end
         htc_pkg::ST_SEG1: begin
            y1_in = rd_data.level;
            if (!span_bad) begin
               div_start    = 1'b1;
               div_dividend = DIVW'(dx_scaled);
               div_divisor  = rd_data.key - k0_ff;
            end
         end
         htc_pkg::ST_DIV_T: begin
            if (div_stat.done) ti_in = div_quot[15:0];
         end
         htc_pkg::ST_MUL_A: begin
            a_in = ti_ff * ti_ff;
         end
         htc_pkg::ST_MUL_C: begin
            fold_s_in = ti_ff * a_ff;
            fold_q_in = '0;
         end
         htc_pkg::ST_DIV_C: begin
            if (fold_busy) begin
               fold_s_in = 48'(fold_hi) + {32'h0, fold_s_ff[15:0]};
               fold_q_in = fold_q_ff + 48'(fold_hi);
            end else begin
               c_in = fold_quo[31:0];
            end
         end
         htc_pkg::ST_HB: begin
            h00_in     = D_SQ - 36'sd3 * a_s + 36'sd2 * c_s;
            h01_in     = 36'sd3 * a_s - 36'sd2 * c_s;
            h10_in     = c_s - 36'sd2 * a_s + ti_d;
            h11_in     = c_s - a_s;
            acc_in     = '0;
            mac_cnt_in = '0;
         end
         htc_pkg::ST_MAC: begin
            // level terms carry the tangents' 8 fraction bits
            if (mac_cnt_ff < 3'd2) begin
               prod_in = mul_p64 <<< 8;
            end else begin
               prod_in = mul_p64;
            end
            if (mac_cnt_ff != 3'd0) acc_in = acc_ff + prod_ff;
            mac_cnt_in = mac_cnt_ff + 3'd1;
         end
         htc_pkg::ST_CLAMP: begin
            priority if (n_val < 0) begin
               res_in = '0;
            end else if (m_val >= Q_LIMIT) begin
               res_in = htc_pkg::LEVEL_ONE;
            end else begin
               fold_s_in = m_val[47:0];
               fold_q_in = '0;
            end
         end
         htc_pkg::ST_DIV_Q1: begin
            if (fold_busy) begin
               fold_s_in = 48'(fold_hi) + {32'h0, fold_s_ff[15:0]};
               fold_q_in = fold_q_ff + 48'(fold_hi);
            end else begin
               fold_s_in = fold_quo;
               fold_q_in = '0;
            end
         end
         htc_pkg::ST_DIV_Q2: begin
            if (fold_busy) begin
               fold_s_in = 48'(fold_hi) + {32'h0, fold_s_ff[15:0]};
               fold_q_in = fold_q_ff + 48'(fold_hi);
            end else begin
               res_in = fold_quo[15:0];
            end
         end
         htc_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= htc_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= 6'd2;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) node_count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;  rd_idx_ff <= rd_idx_in;  seg_ff <= seg_in;  found_ff <= found_in;
      k0_ff <= k0_in;  y0_ff <= y0_in;  y1_ff <= y1_in;  m0_ff <= m0_in;  m1_ff <= m1_in;
      ti_ff <= ti_in;  a_ff <= a_in;  c_ff <= c_in;
      h00_ff <= h00_in;  h01_ff <= h01_in;  h10_ff <= h10_in;  h11_ff <= h11_in;
      acc_ff <= acc_in;  prod_ff <= prod_in;  mac_cnt_ff <= mac_cnt_in;
      res_ff <= res_in;  rsp_pixel_ff <= rsp_pixel_in;
      fold_s_ff <= fold_s_in;  fold_q_ff <= fold_q_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

`ifndef ASSERT_OFF
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_seg_has_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == htc_pkg::ST_SEG1) |-> (found_ff && seg_ff != idx_last))
      else $error("segment fetch without a following node");

   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == htc_pkg::ST_DIV_T))
      else $error("divider result with no state waiting for it");

   a_finish_posts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == htc_pkg::ST_FINISH && out_free) |=>
         (rsp_valid_ff && state_ff == htc_pkg::ST_IDLE))
      else $error("finished item not posted");
`endif

endmodule

`default_nettype wire

FILE: verif/hermite_tone_curve_eval_test.sv
// ----------------------------------------------------------------------------
// hermite_tone_curve_eval_test: self-checking bench for the tone curve block
// Builds node tables, then streams evaluate and load items under several node
// counts with random idle bursts on both channels. Every mapped pixel is
// checked against a fixed-point Hermite predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hermite_tone_curve_eval_test;

   localparam int SLOTS = htc_pkg::MAX_NODES_DEFAULT;
   localparam int DRAIN_CYCLES = 300;
   localparam int CYCLE_LIMIT = 2000000;

   typedef enum logic {ACT_EVAL = 1'b0, ACT_LOAD = 1'b1} action_type;

   class curve_scoreboard;
      logic [15:0]        keys[SLOTS];
      logic [15:0]        levels[SLOTS];
      logic signed [23:0] slope_in[SLOTS];
      logic signed [23:0] slope_out[SLOTS];
      logic [5:0]         count_reg = 6'd2;
      logic [15:0]        pending_levels[$];
      int                 errors = 0;
      int                 evals = 0;
      int                 loads = 0;

      function logic [15:0] map_level(logic [15:0] x);
         longint d, k0, span, ti, a, c, h00, h01, h10, h11, num, q;
         int n, seg;
         d = 65535;
         n = count_reg;
         if (n < 2) n = 2;
         if (n > SLOTS) n = SLOTS;
         seg = -1;
         for (int i = 0; i < n; i++)
            if (keys[i] <= x) seg = i;
         if (seg < 0) return levels[0];
         if (keys[seg] == x || seg == n - 1) return levels[seg];
         k0 = longint'(keys[seg]);
         span = longint'(keys[seg + 1]) - k0;
         if (span <= 0) return levels[seg];
         ti = ((longint'(x) - k0) * d) / span;
         if (ti > d) ti = d;
         a = ti * ti;
         c = (ti * a) / d;
         h00 = d * d - 3 * a + 2 * c;
         h01 = 3 * a - 2 * c;
         h10 = c - 2 * a + ti * d;
         h11 = c - a;
         num = 256 * (longint'(levels[seg]) * h00 + longint'(levels[seg + 1]) * h01)
               + longint'(slope_in[seg]) * h10 + longint'(slope_out[seg]) * h11;
         if (num < 0) return 16'd0;
         q = num / (256 * d * d);
         if (q > 65535) q = 65535;
         return q[15:0];
      endfunction

      function void note_item(action_type act, logic [15:0] pix, logic [4:0] idx,
                              logic [15:0] x, logic [15:0] y,
                              logic signed [23:0] ts, logic signed [23:0] te);
         if (act == ACT_LOAD) begin
            keys[idx] = x;
            levels[idx] = y;
            slope_in[idx] = ts;
            slope_out[idx] = te;
            loads++;
         end else begin
            pending_levels.push_back(map_level(pix));
            evals++;
         end
      endfunction

      function void check_result(logic [15:0] got);
         logic [15:0] want;
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected result pixel_out=%0d", $time, got);
            errors++;
            return;
         end
         want = pending_levels.pop_front();
         if (got !== want) begin
            $display("%0t: pixel_out mismatch expected=%0d actual=%0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_action = 1'b0;
   logic [15:0]        req_pixel_in = '0;
   logic [4:0]         req_node_index = '0;
   logic [15:0]        req_node_x = '0;
   logic [15:0]        req_node_y = '0;
   logic signed [23:0] req_tangent_start = '0;
   logic signed [23:0] req_tangent_end = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [15:0]        rsp_pixel_out;
   logic               csr_write_enable = 1'b0;
   logic [5:0]         csr_write_data = '0;

   curve_scoreboard sb = new();
   bit quiet = 1'b0;   // no idling on either side
   int stall_left = 0;
   int cycles = 0;
   int settings = 0;

   hermite_tone_curve_eval dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_pixel_in(req_pixel_in), .req_node_index(req_node_index),
      .req_node_x(req_node_x), .req_node_y(req_node_y),
      .req_tangent_start(req_tangent_start), .req_tangent_end(req_tangent_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_pixel_out(rsp_pixel_out),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("** hermite_tone_curve_eval: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_pixel_out);
   end

   // leaves valid high on return; the caller lowers it or sends again
   task automatic send_item(action_type act, logic [15:0] pix, logic [4:0] idx,
                            logic [15:0] x, logic [15:0] y,
                            logic signed [23:0] ts, logic signed [23:0] te);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_pixel_in <= pix;
      req_node_index <= idx;
      req_node_x <= x;
      req_node_y <= y;
      req_tangent_start <= ts;
      req_tangent_end <= te;
      do @(posedge clock); while (!req_ready);
      sb.note_item(act, pix, idx, x, y, ts, te);
   endtask

   task automatic evaluate_pixel(logic [15:0] pix);
      send_item(ACT_EVAL, pix, 5'($urandom), 16'($urandom), 16'($urandom),
                24'($urandom), 24'($urandom));
   endtask

   task automatic load_node(int idx, logic [15:0] x, logic [15:0] y,
                            logic signed [23:0] ts, logic signed [23:0] te);
      send_item(ACT_LOAD, 16'($urandom), idx[4:0], x, y, ts, te);
   endtask

   function automatic logic signed [23:0] pick_slope();
      if ($urandom_range(0, 4) == 0) return 24'($urandom);
      return 24'(int'($urandom_range(0, 2 ** 22)) - 2 ** 21);
   endfunction

   // block is idle once nothing is pending and the last evaluate has drained
   task automatic write_count(logic [5:0] value);
      req_valid <= 1'b0;
      while (sb.pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.count_reg = value;
      settings++;
   endtask

   // shape: 0 sorted curve spanning 0..65535, 1 first key above zero, 2 unsorted
   task automatic build_curve(int n, int shape);
      int step, k;
      if (n < 2) n = 2;
      if (n > SLOTS) n = SLOTS;
      step = 65535 / (n - 1);
      for (int i = 0; i < SLOTS; i++) begin
         if (i >= n || shape == 2) k = $urandom_range(0, 65535);
         else if (i == n - 1) k = 65535;
         else if (i == 0) k = (shape == 1) ? $urandom_range(1, step / 2) : 0;
         else k = i * step + $urandom_range(0, step / 2);
         load_node(i, k[15:0], 16'($urandom), pick_slope(), pick_slope());
      end
   endtask

   function automatic logic [15:0] pick_pixel();
      int n, k;
      n = sb.count_reg < 2 ? 2 : (sb.count_reg > SLOTS ? SLOTS : sb.count_reg);
      k = sb.keys[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 7))
         0: return 16'(k);
         1: return 16'(k + 1);
         2: return 16'(k - 1);
         3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_phase(logic [5:0] count_value, int shape, int items);
      write_count(count_value);
      build_curve(count_value, shape);
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(0, 9) == 0)
            load_node($urandom_range(0, SLOTS - 1), 16'($urandom), 16'($urandom),
                      pick_slope(), pick_slope());
         else
            evaluate_pixel(pick_pixel());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: full table, extremes, node hits and neighbors, steep tangents
      write_count(6'd32);
      build_curve(32, 0);
      evaluate_pixel(16'h0000);
      evaluate_pixel(16'hFFFF);
      evaluate_pixel(sb.keys[5]);
      evaluate_pixel(sb.keys[5] + 16'd1);
      evaluate_pixel(sb.keys[6] - 16'd1);
      evaluate_pixel(sb.keys[31] - 16'd1);
      load_node(0, 16'h0000, 16'hFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
      load_node(1, 16'hFFFF, 16'hFFFF, 24'sh000000, 24'sh000000);
      write_count(6'd2);
      evaluate_pixel(16'h4000);    // overshoot clamps high
      load_node(0, 16'h0000, 16'h0000, 24'sh800000, 24'sh800000);
      load_node(1, 16'hFFFF, 16'h0000, 24'sh000000, 24'sh800000);
      evaluate_pixel(16'h4000);    // undershoot clamps to zero
      evaluate_pixel(16'h8000);
      load_node(0, 16'h1000, 16'h1234, 24'sh000100, 24'shFFFF00);
      evaluate_pixel(16'h0FFF);    // below the first key
      evaluate_pixel(16'h1000);

      run_phase(6'd2, 0, 100);
      run_phase(6'd0, 1, 80);
      run_phase(6'd1, 2, 80);
      run_phase(6'd63, 0, 110);
      run_phase(6'd33, 2, 80);
      run_phase(6'($urandom_range(3, 31)), 0, 110);
      run_phase(6'($urandom_range(3, 31)), 1, 110);
      run_phase(6'($urandom_range(3, 31)), 2, 80);
      run_phase(6'd32, 0, 110);
      quiet = 1'b1;
      run_phase(6'($urandom_range(2, 32)), 0, 110);

      req_valid <= 1'b0;
      while (sb.pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d evaluates and %0d node loads over %0d node count settings,",
               sb.evals, sb.loads, settings);
      $display("sorted, offset and unsorted curves; %0d mismatches.", sb.errors);
      if (sb.errors == 0) begin
         $display("** hermite_tone_curve_eval: PASSED **");
      end else begin
         $display("** hermite_tone_curve_eval: FAILED **");
      end
      $finish;
   end

endmodule
